@@ hw/rtl/led_pwm_breathing_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the LED PWM breathing controller
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_PWM_BREATHING_CONTROLLER_ASSERT_SVH
`define LED_PWM_BREATHING_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lpb_pkg.sv @@
// ----------------------------------------------------------------------------
// lpb_pkg
// Types and constants for the LED PWM breathing controller.
// ----------------------------------------------------------------------------
`default_nettype none
package lpb_pkg;
    localparam int FLAME_TOP_GEAR_DEF    = 8;
    localparam int DOWN_TOP_GEAR_DEF     = 8;
    localparam int FLAME_PATTERN_MAX_DEF = 6;
    localparam int DOWN_PATTERN_MAX_DEF  = 6;

    localparam logic [7:0] FRAME_LAST   = 8'd199;
    localparam logic [7:0] BREATH_LAST  = 8'd205;
    localparam logic [7:0] ON_ALWAYS    = 8'd200;
    localparam logic [7:0] OFFSET_START = 8'd5;

    typedef enum logic [2:0] {
        OP_PWM   = 3'd0,
        OP_BRTH  = 3'd1,
        OP_FINIT = 3'd2,
        OP_DINIT = 3'd3,
        OP_GINIT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_LEVEL0   = 3'd0,
        REG_LEVEL1   = 3'd1,
        REG_LEVEL2   = 3'd2,
        REG_LEVEL3   = 3'd3,
        REG_LVL_EN   = 3'd4,
        REG_DIV_MAIN = 3'd5,
        REG_DIV_GRN  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] op;
        logic       standby;
        logic [3:0] flame_gear;
        logic [3:0] down_gear;
        logic       show_on;
        logic       heater_on;
        logic       heat_lock;
        logic       lock_flash;
        logic       lock_on;
        logic [2:0] flame_level_sel;
        logic [2:0] down_level_sel;
    } in_item_t;

    typedef struct packed {
        logic motor;
        logic flame_yellow;
        logic flame_blue;
        logic flame_red;
        logic down_red;
        logic down_blue;
        logic down_green;
    } out_item_t;

    // colour bit0 -> first pin of group, bit2 -> last
    function automatic logic [2:0] flame_colour(input logic [3:0] idx);
        logic [2:0] c;
        case (idx)
            4'd0: c = 3'd0;
            4'd1: c = 3'd1;
            4'd2: c = 3'd2;
            4'd3: c = 3'd4;
            4'd4: c = 3'd3;
            4'd5: c = 3'd5;
            4'd6: c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] down_colour(input logic [3:0] idx);
        logic [2:0] c;
        case (idx)
            4'd0: c = 3'd0;
            4'd1: c = 3'd5;
            4'd2: c = 3'd2;
            4'd3: c = 3'd4;
            4'd4: c = 3'd3;
            4'd5: c = 3'd5;
            4'd6: c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    // x / 10 for x < 256 by reciprocal multiply
    function automatic logic [4:0] div10(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return p[15:11];
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/led_pwm_breathing_controller.sv @@
// ----------------------------------------------------------------------------
// led_pwm_breathing_controller
// Software-style PWM and breathing engine for a motor pin and two RGB groups.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one event item (PWM tick, breathing tick or
//   an init). Each accepted item yields one m_item: the seven pin levels
//   after the event. Pins hold between events.
//   Config: cfg_we/cfg_index/cfg_wdata write the level table and dividers;
//   write only while idle.
//   Result valid the cycle after acceptance. Throughput: one item per cycle
//   when not stalled; the single state update stage feeds the output reg.
//   s_ready is high whenever the output register is empty or being drained,
//   so a stalled receiver holds one result and then back-pressures input.
//   Reset (aresetn low, synchronous) clears all counters, pins and the
//   output register, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_pwm_breathing_controller_assert.svh"
module led_pwm_breathing_controller #(
    parameter int FLAME_TOP_GEAR    = lpb_pkg::FLAME_TOP_GEAR_DEF,
    parameter int DOWN_TOP_GEAR     = lpb_pkg::DOWN_TOP_GEAR_DEF,
    parameter int FLAME_PATTERN_MAX = lpb_pkg::FLAME_PATTERN_MAX_DEF,
    parameter int DOWN_PATTERN_MAX  = lpb_pkg::DOWN_PATTERN_MAX_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lpb_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lpb_pkg::out_item_t     m_item,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_wdata
);
    import lpb_pkg::*;

    localparam logic [3:0] FTOP = 4'(FLAME_TOP_GEAR);
    localparam logic [3:0] DTOP = 4'(DOWN_TOP_GEAR);
    localparam logic [3:0] FPMAX = 4'(FLAME_PATTERN_MAX);
    localparam logic [3:0] DPMAX = 4'(DOWN_PATTERN_MAX);

    logic [7:0] level0_reg, level1_reg, level2_reg, level3_reg;
    logic       lvl_en_reg;
    logic [7:0] div_main_reg, div_grn_reg;

    logic [6:0] pin_reg, pin_next; // bit i = output field i (0 motor)
    logic [7:0] f_frame_reg, f_frame_next, f_left_reg, f_left_next;
    logic [7:0] d_frame_reg, d_frame_next, d_left_reg, d_left_next;
    logic [7:0] dg_left_reg, dg_left_next;
    logic [7:0] f_div_reg, f_div_next, f_off_reg, f_off_next;
    logic       f_fall_reg, f_fall_next;
    logic [2:0] f_pat_reg, f_pat_next;
    logic [7:0] d_div_reg, d_div_next, d_off_reg, d_off_next;
    logic       d_fall_reg, d_fall_next;
    logic [2:0] d_pat_reg, d_pat_next;
    logic [4:0] d_ten_reg, d_ten_next;
    logic [7:0] g_div_reg, g_div_next, g_off_reg, g_off_next;
    logic       g_fall_reg, g_fall_next;
    logic [4:0] g_ten_reg, g_ten_next;
    logic [7:0] fb_frame_reg, fb_frame_next, fb_cnt_reg, fb_cnt_next;
    logic       fb_on_reg, fb_on_next;
    logic [7:0] db_frame_reg, db_frame_next, db_cnt_reg, db_cnt_next;
    logic       db_on_reg, db_on_next;
    logic [7:0] gb_frame_reg, gb_frame_next, gb_cnt_reg, gb_cnt_next;
    logic       gb_on_reg, gb_on_next;

    logic       m_valid_reg;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_item_t'({pin_reg[0], pin_reg[1], pin_reg[2], pin_reg[3],
                                  pin_reg[4], pin_reg[5], pin_reg[6]});

    function automatic logic [7:0] level_of(input logic [2:0] sel, input logic en,
                                            input logic [7:0] l0, input logic [7:0] l1,
                                            input logic [7:0] l2, input logic [7:0] l3);
        logic [7:0] v;
        if (!en) begin
            v = ON_ALWAYS;
        end else begin
            case (sel)
                3'd0: v = l0;
                3'd1: v = l1;
                3'd2: v = l2;
                3'd3: v = l3;
                default: v = 8'd0;
            endcase
        end
        return v;
    endfunction

    always_comb begin
        logic [3:0] fg, dg;
        logic       show, heat, step, done;
        logic [2:0] c;
        logic [3:0] p;
        logic [7:0] lv;

        fg = s_item.flame_gear;
        dg = s_item.down_gear;
        show = s_item.show_on;
        heat = (fg == 4'd0) && (dg == 4'd0) && s_item.heater_on && !s_item.heat_lock;
        step = 1'b0; done = 1'b0; c = '0; p = '0; lv = '0;

        pin_next = pin_reg;
        f_frame_next = f_frame_reg; f_left_next = f_left_reg;
        d_frame_next = d_frame_reg; d_left_next = d_left_reg; dg_left_next = dg_left_reg;
        f_div_next = f_div_reg; f_off_next = f_off_reg; f_fall_next = f_fall_reg;
        f_pat_next = f_pat_reg;
        d_div_next = d_div_reg; d_off_next = d_off_reg; d_fall_next = d_fall_reg;
        d_pat_next = d_pat_reg; d_ten_next = d_ten_reg;
        g_div_next = g_div_reg; g_off_next = g_off_reg; g_fall_next = g_fall_reg;
        g_ten_next = g_ten_reg;
        fb_frame_next = fb_frame_reg; fb_cnt_next = fb_cnt_reg; fb_on_next = fb_on_reg;
        db_frame_next = db_frame_reg; db_cnt_next = db_cnt_reg; db_on_next = db_on_reg;
        gb_frame_next = gb_frame_reg; gb_cnt_next = gb_cnt_reg; gb_on_next = gb_on_reg;

        case (s_item.op)
            OP_PWM: begin
                if (!s_item.standby) begin
                    pin_next = '0;
                end else begin
                    // flame and motor
                    if ((fg != 4'd0) || show) begin
                        pin_next[0] = 1'b1;
                        if ((fg != FTOP) && !show) begin
                            f_frame_next = f_frame_reg + 8'd1;
                            if (f_frame_next > FRAME_LAST) begin
                                f_frame_next = '0;
                                c = flame_colour(fg);
                                pin_next[3:1] = c;
                                f_left_next = level_of(s_item.flame_level_sel, lvl_en_reg,
                                    level0_reg, level1_reg, level2_reg, level3_reg);
                            end
                            if (f_left_next != ON_ALWAYS) begin
                                if (f_left_next != 8'd0) f_left_next = f_left_next - 8'd1;
                                else pin_next[3:1] = '0;
                            end
                        end
                    end else begin
                        pin_next[0] = 1'b0;
                        pin_next[3:1] = '0;
                    end
                    // downlight
                    if ((dg != 4'd0) || heat || show) begin
                        if ((dg != DTOP) && (dg != 4'd1) && !show) begin
                            d_frame_next = d_frame_reg + 8'd1;
                            if (d_frame_next > FRAME_LAST) begin
                                d_frame_next = '0;
                                if (heat) begin
                                    pin_next[4] = 1'b1;
                                    d_left_next = level2_reg;
                                end else begin
                                    c = down_colour(dg - 4'd1);
                                    pin_next[6:4] = c;
                                    lv = level_of(s_item.down_level_sel, lvl_en_reg,
                                        level0_reg, level1_reg, level2_reg, level3_reg);
                                    d_left_next = lv;
                                    dg_left_next = (dg == 4'd2) ? 8'(div10(lv)) : lv;
                                end
                            end
                            if (d_left_next != ON_ALWAYS) begin
                                if (d_left_next != 8'd0) d_left_next = d_left_next - 8'd1;
                                else pin_next[6:4] = '0;
                            end
                            if (dg_left_next != ON_ALWAYS) begin
                                if (dg_left_next != 8'd0) dg_left_next = dg_left_next - 8'd1;
                                else pin_next[6] = 1'b0;
                            end
                        end
                    end else begin
                        pin_next[6:4] = '0;
                    end
                    // flame breathing
                    if ((fg == FTOP) || show) begin
                        fb_frame_next = fb_frame_reg + 8'd1;
                        if (fb_frame_next > BREATH_LAST) begin
                            fb_frame_next = '0;
                            pin_next[3:1] = flame_colour({1'b0, f_pat_reg} + 4'd1);
                            fb_on_next = 1'b1;
                        end
                        if (fb_on_next) begin
                            fb_cnt_next = fb_cnt_reg + 8'd1;
                            if (fb_cnt_next > f_off_reg) begin
                                fb_cnt_next = '0;
                                fb_on_next = 1'b0;
                                pin_next[3:1] = '0;
                            end
                        end
                    end else begin
                        f_fall_next = 1'b0;
                        f_off_next = '0;
                    end
                    // downlight breathing
                    if ((dg == DTOP) || show) begin
                        db_frame_next = db_frame_reg + 8'd1;
                        if (db_frame_next > BREATH_LAST) begin
                            db_frame_next = '0;
                            pin_next[6:4] = down_colour({1'b0, d_pat_reg} + 4'd1);
                            db_on_next = 1'b1;
                        end
                        if (db_on_next) begin
                            db_cnt_next = db_cnt_reg + 8'd1;
                            if (db_cnt_next > d_off_reg) begin
                                db_cnt_next = '0;
                                db_on_next = 1'b0;
                                pin_next[6:4] = '0;
                            end
                            if ((d_pat_reg == 3'd0) && (db_cnt_next > 8'(d_ten_reg)))
                                pin_next[6] = 1'b0;
                        end
                    end else begin
                        d_fall_next = 1'b0;
                        d_off_next = '0;
                    end
                    // green breathing
                    if ((dg == 4'd1) && !show) begin
                        gb_frame_next = gb_frame_reg + 8'd1;
                        if (gb_frame_next > BREATH_LAST) begin
                            gb_frame_next = '0;
                            pin_next[6:4] = 3'b101;
                            gb_on_next = 1'b1;
                        end
                        if (gb_on_next) begin
                            gb_cnt_next = gb_cnt_reg + 8'd1;
                            if (gb_cnt_next > g_off_reg) begin
                                gb_cnt_next = '0;
                                gb_on_next = 1'b0;
                                pin_next[6:4] = '0;
                            end
                            if (gb_cnt_next > 8'(g_ten_reg)) pin_next[6] = 1'b0;
                        end
                    end else begin
                        gb_on_next = 1'b0;
                        g_off_next = '0;
                    end
                    // lock overrides
                    if (s_item.lock_flash) begin
                        if ((dg == 4'd0) && (pin_next[6:4] == 3'b000)) pin_next[5] = 1'b1;
                    end else if (s_item.lock_on) begin
                        pin_next[6:4] = '0;
                    end
                end
            end
            OP_BRTH: begin
                if (s_item.standby) begin
                    if ((fg == FTOP) || show) begin
                        f_div_next = f_div_reg + 8'd1;
                        if (f_div_next > div_main_reg) begin
                            f_div_next = '0;
                            done = 1'b0;
                            if (!f_fall_reg) begin
                                f_off_next = f_off_reg + 8'd1;
                                if (f_off_reg > FRAME_LAST) f_fall_next = 1'b1;
                            end else if (f_off_reg > OFFSET_START) begin
                                f_off_next = f_off_reg - 8'd1;
                            end else begin
                                f_fall_next = 1'b0;
                                done = 1'b1;
                            end
                            if (done) begin
                                p = {1'b0, f_pat_reg} + 4'd1;
                                f_pat_next = (p > FPMAX) ? 3'd0 : p[2:0];
                            end
                        end
                    end
                    if ((dg == DTOP) || show) begin
                        d_div_next = d_div_reg + 8'd1;
                        if (d_div_next > div_main_reg) begin
                            d_div_next = '0;
                            done = 1'b0;
                            if (!d_fall_reg) begin
                                d_off_next = d_off_reg + 8'd1;
                                if (d_off_reg > FRAME_LAST) d_fall_next = 1'b1;
                            end else if (d_off_reg > OFFSET_START) begin
                                d_off_next = d_off_reg - 8'd1;
                            end else begin
                                d_fall_next = 1'b0;
                                done = 1'b1;
                            end
                            if (done) begin
                                p = {1'b0, d_pat_reg} + 4'd1;
                                d_pat_next = (p > DPMAX) ? 3'd0 : p[2:0];
                            end
                            d_ten_next = div10(d_off_next);
                        end
                    end
                    if (dg == 4'd1) begin
                        g_div_next = g_div_reg + 8'd1;
                        if (g_div_next > div_grn_reg) begin
                            g_div_next = '0;
                            step = 1'b1;
                            if (!g_fall_reg) begin
                                g_off_next = g_off_reg + 8'd1;
                                if (g_off_reg > FRAME_LAST) g_fall_next = 1'b1;
                            end else if (g_off_reg > OFFSET_START) begin
                                g_off_next = g_off_reg - 8'd1;
                            end else begin
                                g_fall_next = 1'b0;
                            end
                            if (step) g_ten_next = div10(g_off_next);
                        end
                    end
                end
            end
            OP_FINIT: begin
                pin_next[2:1] = '0;
                f_pat_next = '0; f_fall_next = 1'b0; f_off_next = OFFSET_START;
            end
            OP_DINIT: begin
                pin_next[6:4] = '0;
                d_pat_next = '0; d_fall_next = 1'b0; d_off_next = OFFSET_START;
            end
            OP_GINIT: begin
                pin_next[6:4] = '0;
                g_fall_next = 1'b0; g_off_next = OFFSET_START;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level0_reg <= 8'd200; level1_reg <= 8'd100;
            level2_reg <= 8'd40;  level3_reg <= 8'd40;
            lvl_en_reg <= 1'b1; div_main_reg <= 8'd33; div_grn_reg <= 8'd18;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEVEL0:   level0_reg <= cfg_wdata;
                REG_LEVEL1:   level1_reg <= cfg_wdata;
                REG_LEVEL2:   level2_reg <= cfg_wdata;
                REG_LEVEL3:   level3_reg <= cfg_wdata;
                REG_LVL_EN:   lvl_en_reg <= cfg_wdata[0];
                REG_DIV_MAIN: div_main_reg <= cfg_wdata;
                REG_DIV_GRN:  div_grn_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pin_reg <= '0;
            f_frame_reg <= '0; f_left_reg <= '0;
            d_frame_reg <= '0; d_left_reg <= '0; dg_left_reg <= '0;
            f_div_reg <= '0; f_off_reg <= '0; f_fall_reg <= 1'b0; f_pat_reg <= '0;
            d_div_reg <= '0; d_off_reg <= '0; d_fall_reg <= 1'b0; d_pat_reg <= '0;
            d_ten_reg <= '0;
            g_div_reg <= '0; g_off_reg <= '0; g_fall_reg <= 1'b0; g_ten_reg <= '0;
            fb_frame_reg <= '0; fb_cnt_reg <= '0; fb_on_reg <= 1'b0;
            db_frame_reg <= '0; db_cnt_reg <= '0; db_on_reg <= 1'b0;
            gb_frame_reg <= '0; gb_cnt_reg <= '0; gb_on_reg <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
                pin_reg <= pin_next;
                f_frame_reg <= f_frame_next; f_left_reg <= f_left_next;
                d_frame_reg <= d_frame_next; d_left_reg <= d_left_next;
                dg_left_reg <= dg_left_next;
                f_div_reg <= f_div_next; f_off_reg <= f_off_next;
                f_fall_reg <= f_fall_next; f_pat_reg <= f_pat_next;
                d_div_reg <= d_div_next; d_off_reg <= d_off_next;
                d_fall_reg <= d_fall_next; d_pat_reg <= d_pat_next;
                d_ten_reg <= d_ten_next;
                g_div_reg <= g_div_next; g_off_reg <= g_off_next;
                g_fall_reg <= g_fall_next; g_ten_reg <= g_ten_next;
                fb_frame_reg <= fb_frame_next; fb_cnt_reg <= fb_cnt_next;
                fb_on_reg <= fb_on_next;
                db_frame_reg <= db_frame_next; db_cnt_reg <= db_cnt_next;
                db_on_reg <= db_on_next;
                gb_frame_reg <= gb_frame_next; gb_cnt_reg <= gb_cnt_next;
                gb_on_reg <= gb_on_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `LPB_ASSERT_NXT(a_accept_gives_result, aclk, aresetn, accept, m_valid)
    `LPB_ASSERT_NXT(a_stall_holds_pins, aclk, aresetn, m_valid && !m_ready, $stable(pin_reg))
    `LPB_ASSERT_IMP(a_pattern_range, aclk, aresetn, 1'b1,
        (4'(f_pat_reg) <= FPMAX || f_pat_reg == 3'd0) &&
        (4'(d_pat_reg) <= DPMAX || d_pat_reg == 3'd0))
    `LPB_ASSERT_NXT(a_standby_off, aclk, aresetn,
        accept && s_item.op == OP_PWM && !s_item.standby, pin_reg == 7'd0)
endmodule
`default_nettype wire
